/* src/decimal_normalize_round_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decimal normalize and round core
// Concurrent check wrappers that compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_NORMALIZE_ROUND_CORE_MACROS_SVH
`define DECIMAL_NORMALIZE_ROUND_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checks that an implication holds at every clock edge outside reset.
`define DNR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define DNR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DNR_ASSERT(lbl, prop, msg)
`define DNR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/dnr_pkg.sv */
// ----------------------------------------------------------------------------
// Decimal normalize and round package
// Sequencer states, status codes and divide-by-ten constants.
// ----------------------------------------------------------------------------
package dnr_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCALE = 5'b00010,
        S_STRIP = 5'b00100,
        S_FIT   = 5'b01000,
        S_ROUND = 5'b10000
    } state_t;

    // Result status codes.
    localparam logic [2:0] ST_NORMAL    = 3'd0;
    localparam logic [2:0] ST_PLUS_INF  = 3'd1;
    localparam logic [2:0] ST_MINUS_INF = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    // Exponent limits.
    localparam logic [7:0] MAX_SCALE = 8'd28;
    localparam logic [7:0] MAX_EXP   = 8'd127;

    // The divider walks the 112-bit coefficient in four 28-bit chunks. With the
    // 4-bit remainder in front, each partial dividend is 32 bits, and
    // floor(x / 10) equals (x * 0xCCCCCCCD) >> 35 for every 32-bit x.
    localparam int         DIV_CHUNK  = 28;
    localparam int         DIV_SHIFT  = 35;
    localparam logic [31:0] DIV_RECIP = 32'hCCCC_CCCD;

endpackage

/* src/decimal_normalize_round_core.sv */
// ----------------------------------------------------------------------------
// Decimal normalize and round core
// Scales a 112-bit decimal coefficient to 96 bits with exponent 0..28,
// rounding half to even on the last digit dropped.
// ----------------------------------------------------------------------------
// After the input word is taken, each divide-by-ten pass walks the four chunks
// in turn, and S_ROUND then rounds and loads the output register; at most 128
// passes run (127 exponent steps and one strip pass that finds a nonzero digit).
// A new word is taken only once the last result is loaded, which waits on
// m_tready; the shared divider takes one 28-bit chunk per cycle.
// Reset: synchronous, active low; clears the sequencer and output valid only.
// ----------------------------------------------------------------------------
`include "decimal_normalize_round_core_macros.svh"

module decimal_normalize_round_core (
    input  logic         aclk,
    input  logic         aresetn,

    // Input words.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, lowest bit up: in_coeff_low[63:0], in_coeff_high[95:64],
    // in_coeff_ext[111:96], in_exponent[119:112], in_sign[120], zero fill.
    input  logic [127:0] s_tdata,

    // Result words.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, lowest bit up: out_coeff_low[63:0], out_coeff_high[95:64],
    // out_exponent[100:96], out_sign[101], zero fill.
    output logic [103:0] m_tdata,
    // m_tuser: out_status[2:0].
    output logic [2:0]   m_tuser
);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    dnr_pkg::state_t state_reg, state_next;

    // Working coefficient and the quotient chunks built during one step.
    logic [111:0] coeff_reg, coeff_next;
    logic [83:0]  quo_reg, quo_next;
    logic [3:0]   rem_reg, rem_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [7:0]   exp_reg, exp_next;
    logic [2:0]   status_reg, status_next;
    logic         sign_reg, sign_next;
    // Digit dropped by the latest fit step, used for rounding.
    logic [3:0]   last_reg, last_next;

    // Output register.
    logic         m_valid_reg, m_valid_next;
    logic [103:0] m_data_reg, m_data_next;
    logic [2:0]   m_user_reg, m_user_next;

    // ------------------------------------------------------------------------
    // Shared divide-by-ten unit: one 28-bit chunk per cycle, top chunk first.
    // The remainder of one chunk is prepended to the next one.
    // ------------------------------------------------------------------------
    logic [1:0]   chunk_sel;
    logic [27:0]  chunk;
    logic [31:0]  div_x;
    logic [63:0]  prod;
    logic [27:0]  q_now;
    logic [3:0]   r_now;
    logic [111:0] quot_full;
    logic         quot_zero;
    logic         quot_top_nz;
    logic         last_step;
    logic [7:0]   exp_dec;

    assign chunk_sel = ~cnt_reg;
    assign chunk     = coeff_reg[chunk_sel * dnr_pkg::DIV_CHUNK +: dnr_pkg::DIV_CHUNK];
    assign div_x     = {rem_reg, chunk};
    assign prod      = 64'(div_x) * 64'(dnr_pkg::DIV_RECIP);
    assign q_now     = prod[dnr_pkg::DIV_SHIFT +: dnr_pkg::DIV_CHUNK];
    // Only the low four bits of x - 10q matter since the remainder is below ten.
    assign r_now     = div_x[3:0] - ({q_now[0], 3'b000} + {q_now[2:0], 1'b0});

    assign quot_full   = {quo_reg, q_now};
    assign quot_zero   = (quot_full == 112'd0);
    assign quot_top_nz = |quot_full[111:96];
    assign last_step   = (cnt_reg == 2'd3);
    assign exp_dec     = exp_reg - 8'd1;

    // ------------------------------------------------------------------------
    // Input unpacking. An exponent above 127 marks infinity: the exponent
    // becomes zero and the extension bits are dropped.
    // ------------------------------------------------------------------------
    logic [111:0] in_coeff;
    logic [7:0]   in_exp;
    logic         in_sign;
    logic         in_inf;
    logic [111:0] in_coeff_fix;
    logic [7:0]   in_exp_fix;
    logic [2:0]   in_status;

    assign in_coeff     = s_tdata[111:0];
    assign in_exp       = s_tdata[119:112];
    assign in_sign      = s_tdata[120];
    assign in_inf       = (in_exp > dnr_pkg::MAX_EXP);
    assign in_coeff_fix = in_inf ? {16'd0, in_coeff[95:0]} : in_coeff;
    assign in_exp_fix   = in_inf ? 8'd0 : in_exp;
    assign in_status    = in_inf ? (in_sign ? dnr_pkg::ST_MINUS_INF : dnr_pkg::ST_PLUS_INF)
                                 : dnr_pkg::ST_NORMAL;

    // ------------------------------------------------------------------------
    // Rounding and result assembly. Extension bits still set here mean the
    // exponent ran out before the coefficient fit in 96 bits.
    // ------------------------------------------------------------------------
    logic        round_up;
    logic [96:0] round_sum;
    logic        ovf;
    logic        out_free;

    assign round_up  = (last_reg > 4'd5) || ((last_reg == 4'd5) && coeff_reg[0]);
    assign round_sum = {1'b0, coeff_reg[95:0]} + 97'(round_up);
    assign ovf       = (|coeff_reg[111:96]) || round_sum[96];
    assign out_free  = !m_valid_reg || m_tready;

    // Picks the next loop to run. The loops run in order (scale down to 28,
    // strip trailing zeros, fit into 96 bits) and never go back.
    function automatic dnr_pkg::state_t pick_state(input logic       allow_scale,
                                                   input logic       allow_strip,
                                                   input logic [7:0] e,
                                                   input logic       top_nz);
        dnr_pkg::state_t s;
        priority if (allow_scale && (e > dnr_pkg::MAX_SCALE)) begin
            s = dnr_pkg::S_SCALE;
        end else if (allow_strip && (e != 8'd0)) begin
            s = dnr_pkg::S_STRIP;
        end else if (top_nz && (e != 8'd0)) begin
            s = dnr_pkg::S_FIT;
        end else begin
            s = dnr_pkg::S_ROUND;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        coeff_next   = coeff_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        exp_next     = exp_reg;
        status_next  = status_reg;
        sign_next    = sign_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        unique case (state_reg)
            dnr_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    coeff_next  = in_coeff_fix;
                    exp_next    = in_exp_fix;
                    status_next = in_status;
                    sign_next   = in_sign;
                    last_next   = 4'd0;
                    cnt_next    = 2'd0;
                    rem_next    = 4'd0;
                    state_next  = pick_state(1'b1, 1'b1, in_exp_fix, |in_coeff_fix[111:96]);
                end
            end

            dnr_pkg::S_SCALE, dnr_pkg::S_STRIP, dnr_pkg::S_FIT: begin
                // Walk the chunks; the full quotient is known in the last cycle.
                quo_next = {quo_reg[55:0], q_now};
                cnt_next = cnt_reg + 2'd1;
                rem_next = last_step ? 4'd0 : r_now;
                if (last_step) begin
                    if (state_reg == dnr_pkg::S_SCALE) begin
                        // Truncating scale-down; a zero result means underflow.
                        coeff_next = quot_full;
                        exp_next   = exp_dec;
                        if (quot_zero) begin
                            status_next = dnr_pkg::ST_UNDERFLOW;
                        end
                        state_next = pick_state(1'b1, 1'b1, exp_dec, quot_top_nz);
                    end else if (state_reg == dnr_pkg::S_STRIP) begin
                        // Commit only when the dropped digit is zero.
                        if (r_now == 4'd0) begin
                            coeff_next = quot_full;
                            exp_next   = exp_dec;
                            state_next = pick_state(1'b0, 1'b1, exp_dec, quot_top_nz);
                        end else begin
                            state_next = pick_state(1'b0, 1'b0, exp_reg,
                                                    |coeff_reg[111:96]);
                        end
                    end else begin
                        coeff_next = quot_full;
                        exp_next   = exp_dec;
                        last_next  = r_now;
                        state_next = pick_state(1'b0, 1'b0, exp_dec, quot_top_nz);
                    end
                end
            end

            dnr_pkg::S_ROUND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (ovf) begin
                        m_data_next = {2'd0, sign_reg, 5'd0, 96'd0};
                        m_user_next = dnr_pkg::ST_OVERFLOW;
                    end else begin
                        m_data_next = {2'd0, sign_reg, exp_reg[4:0], round_sum[95:0]};
                        m_user_next = status_reg;
                    end
                    state_next = dnr_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = dnr_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dnr_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Data registers.
    always_ff @(posedge aclk) begin
        coeff_reg  <= coeff_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        exp_reg    <= exp_next;
        status_reg <= status_next;
        sign_reg   <= sign_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == dnr_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `DNR_ASSERT(a_out_exp_range, m_tvalid |-> (m_tdata[100:96] <= 5'd28), "result exponent above 28")
    `DNR_ASSERT(a_ovf_zero, (m_tvalid && (m_tuser == dnr_pkg::ST_OVERFLOW)) |-> (m_tdata[100:0] == 101'd0), "overflow result not zero")
    `DNR_ASSERT(a_fit_exp, (state_reg == dnr_pkg::S_FIT) |-> (exp_reg != 8'd0), "fit step with zero exponent")
    `DNR_ASSERT(a_scale_exp, (state_reg == dnr_pkg::S_SCALE) |-> (exp_reg > dnr_pkg::MAX_SCALE), "scale step at exponent 28 or below")
    `DNR_ASSERT(a_rem_range, (state_reg != dnr_pkg::S_IDLE) |-> (rem_reg < 4'd10), "divider remainder out of range")
    `DNR_ASSERT_NEXT(a_result_load, (state_reg == dnr_pkg::S_ROUND) && (!m_valid_reg || m_tready), m_tvalid && s_tready, "rounded result not loaded")

endmodule

/* tb/sv/decimal_normalize_round_core_test.sv */
// ----------------------------------------------------------------------------
// Decimal normalize and round core testbench
// Drives coefficient, exponent and sign words into the core and checks every
// result word against an in-bench model of scaling, zero stripping, fitting
// to 96 bits and half-to-even rounding, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module decimal_normalize_round_core_test;

    // The longest correct run is far below this; it only catches a hang.
    localparam int CYCLE_LIMIT    = 3_000_000;
    // Long enough for a word's full run of divide steps and its rounding step.
    localparam int DRAIN_CYCLES   = 600;
    localparam int RANDOM_PER_RUN = 175;

    localparam logic [111:0] ALL_ONES = '1;
    localparam logic [111:0] MAX96    = {16'd0, {96{1'b1}}};

    // One expected result word, split into its fields.
    typedef struct packed {
        logic [63:0] coeff_low;
        logic [31:0] coeff_high;
        logic [4:0]  exponent;
        logic        sign;
        logic [2:0]  status;
    } norm_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each accepted input word and checks result words
    // against the oldest prediction.
    // ------------------------------------------------------------------------
    class normalize_scoreboard;
        norm_result_t pending_results[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Scale down to exponent 28, strip trailing zeros, fit into 96 bits
        // and round half to even on the last digit dropped while fitting.
        function norm_result_t scale_and_round(logic [127:0] word);
            logic [111:0] coeff;
            logic [96:0]  rounded;
            logic [3:0]   last;
            logic [2:0]   status;
            logic         ovf;
            int           exp;
            norm_result_t res;
            coeff  = word[111:0];
            exp    = int'(word[119:112]);
            status = dnr_pkg::ST_NORMAL;
            last   = 4'd0;
            ovf    = 1'b0;
            if (exp > int'(dnr_pkg::MAX_EXP)) begin
                exp           = 0;
                coeff[111:96] = 16'd0;
                status        = word[120] ? dnr_pkg::ST_MINUS_INF : dnr_pkg::ST_PLUS_INF;
            end
            while (exp > int'(dnr_pkg::MAX_SCALE)) begin
                coeff = coeff / 10;
                exp--;
                if (coeff == 0)
                    status = dnr_pkg::ST_UNDERFLOW;
            end
            while (exp != 0 && coeff % 10 == 0) begin
                coeff = coeff / 10;
                exp--;
            end
            while (coeff[111:96] != 0 && !ovf) begin
                if (exp == 0) begin
                    ovf = 1'b1;
                end else begin
                    last  = 4'(coeff % 10);
                    coeff = coeff / 10;
                    exp--;
                end
            end
            if (!ovf && (last > 5 || (last == 5 && coeff[0]))) begin
                rounded      = {1'b0, coeff[95:0]} + 97'd1;
                ovf          = rounded[96];
                coeff[95:0]  = rounded[95:0];
            end
            if (ovf) begin
                coeff  = '0;
                exp    = 0;
                status = dnr_pkg::ST_OVERFLOW;
            end
            res.coeff_low  = coeff[63:0];
            res.coeff_high = coeff[95:64];
            res.exponent   = 5'(exp);
            res.sign       = word[120];
            res.status     = status;
            return res;
        endfunction

        function void note_input(logic [127:0] word);
            pending_results.push_back(scale_and_round(word));
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(logic [103:0] data, logic [2:0] status);
            norm_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result word arrived with no input word waiting");
                return;
            end
            want = pending_results.pop_front();
            if (data[63:0] !== want.coeff_low)
                report_mismatch($sformatf("coeff_low got %h expected %h",
                                          data[63:0], want.coeff_low));
            if (data[95:64] !== want.coeff_high)
                report_mismatch($sformatf("coeff_high got %h expected %h",
                                          data[95:64], want.coeff_high));
            if (data[100:96] !== want.exponent)
                report_mismatch($sformatf("exponent got %0d expected %0d",
                                          data[100:96], want.exponent));
            if (data[101] !== want.sign)
                report_mismatch($sformatf("sign got %b expected %b",
                                          data[101], want.sign));
            if (status !== want.status)
                report_mismatch($sformatf("status got %0d expected %0d",
                                          status, want.status));
        endtask
    endclass

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;

    // Percentages of cycles in which the sender holds back a word and the
    // receiver refuses one. The main sequence changes them between phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    normalize_scoreboard board = new();

    decimal_normalize_round_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hang guard. A run that reaches this count has lost a result word.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** decimal_normalize_round_core: FAILED **");
            $finish;
        end
    end

    // The receiver decides each cycle whether it takes a result word. The
    // value sampled at an edge is the one set at the previous edge, so the
    // handshake seen here matches the one the core sees.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    // Input word layout from the lowest bit: coefficient[111:0],
    // exponent[119:112], sign[120], zero fill up to 128 bits.
    function automatic logic [127:0] pack_word(logic [111:0] coeff, logic [7:0] exp,
                                               logic sign);
        return {7'd0, sign, exp, coeff};
    endfunction

    function automatic logic [111:0] pow_ten(int n);
        logic [111:0] p;
        p = 112'd1;
        for (int i = 0; i < n; i++)
            p = p * 10;
        return p;
    endfunction

    // A coefficient of the form head * 10^n + tail. With head at or above
    // 2^95 every one of the n digits of tail is dropped while fitting into
    // 96 bits, so the top digit of tail decides the rounding.
    function automatic logic [111:0] split_digits(logic [111:0] head, int n,
                                                  logic [111:0] tail);
        return head * pow_ten(n) + tail;
    endfunction

    // Random input word. Most kinds aim at one stage of the normalization;
    // the last kind is plain noise over every field.
    function automatic logic [127:0] random_word();
        logic [111:0] coeff;
        logic [111:0] head;
        logic [111:0] tail;
        logic [111:0] scale;
        logic [7:0]   exp;
        int           n;
        coeff = 112'({$urandom, $urandom, $urandom, $urandom});
        exp   = 8'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                coeff = coeff >> $urandom_range(0, 111);
                exp   = 8'($urandom_range(0, 40));
            end
            3: begin
                coeff = coeff >> $urandom_range(0, 60);
                exp   = 8'($urandom_range(29, 127));
            end
            4: begin
                exp = 8'($urandom_range(128, 255));
            end
            5: begin
                // Many trailing zero digits for the stripping stage.
                coeff = (coeff >> 72) * pow_ten($urandom_range(0, 25));
                exp   = 8'($urandom_range(0, 40));
            end
            6, 7: begin
                n     = $urandom_range(1, 3);
                scale = pow_ten(n);
                if ($urandom_range(0, 1))
                    head = MAX96 - 112'($urandom_range(0, 3));
                else
                    head = {16'd0, 1'b1, coeff[94:0]};
                tail = 112'($urandom) % scale;
                // Half the time the deciding digit is exactly five.
                if ($urandom_range(0, 1))
                    tail = 5 * (scale / 10) + tail % (scale / 10);
                coeff = split_digits(head, n, tail);
                exp   = 8'($urandom_range(0, n + 2));
            end
            8: begin
                coeff = $urandom_range(0, 1) ? ALL_ONES : '0;
            end
            default: begin
            end
        endcase
        return pack_word(coeff, exp, 1'($urandom));
    endfunction

    // Offers one input word, first holding back for a random number of
    // cycles, and notes it once the core has taken it. Called right after a
    // rising edge; leaves s_tvalid high so back-to-back words need no gap.
    task automatic send_word(logic [127:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_input(word);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: field extremes, both infinities, underflow,
        // stripping, both overflow causes and the rounding corner cases.
        send_word(pack_word('0, 8'd0, 1'b0));
        send_word(pack_word('0, 8'd28, 1'b1));
        send_word(pack_word(ALL_ONES, 8'd0, 1'b0));
        send_word(pack_word(ALL_ONES, 8'd28, 1'b1));
        send_word(pack_word(ALL_ONES, 8'd255, 1'b0));
        send_word(pack_word(ALL_ONES, 8'd128, 1'b1));
        send_word(pack_word(112'd1, 8'd127, 1'b0));
        send_word(pack_word(112'd9, 8'd29, 1'b1));
        send_word(pack_word(ALL_ONES, 8'd127, 1'b0));
        send_word(pack_word(pow_ten(20), 8'd28, 1'b0));
        send_word(pack_word(pow_ten(30), 8'd0, 1'b0));
        send_word(pack_word(pow_ten(30), 8'd28, 1'b1));
        send_word(pack_word(pow_ten(30), 8'd29, 1'b0));
        send_word(pack_word(pow_ten(28), 8'd28, 1'b1));
        send_word(pack_word(112'd5, 8'd1, 1'b0));
        send_word(pack_word({16'h8000, 96'd0}, 8'd5, 1'b1));
        // Odd head with a dropped five: the carry runs past bit 95.
        send_word(pack_word(split_digits(MAX96, 1, 112'd5), 8'd1, 1'b0));
        // Even head with a dropped five stays put; an odd one rounds up.
        send_word(pack_word(split_digits(MAX96 - 1, 1, 112'd5), 8'd1, 1'b0));
        send_word(pack_word(split_digits(MAX96 - 2, 1, 112'd5), 8'd1, 1'b1));
        send_word(pack_word(split_digits(MAX96 - 1, 1, 112'd6), 8'd1, 1'b0));
        send_word(pack_word(split_digits(MAX96 - 1, 1, 112'd4), 8'd1, 1'b1));
        send_word(pack_word(split_digits(MAX96, 1, 112'd9), 8'd1, 1'b0));
        // A nine dropped before the deciding five must not count.
        send_word(pack_word(split_digits(MAX96 - 3, 2, 112'd59), 8'd2, 1'b0));
        // Two digits must go but the exponent allows only one.
        send_word(pack_word(split_digits(MAX96 - 3, 2, 112'd1), 8'd1, 1'b1));

        // Random words under four idle mixes: none, sender gaps, receiver
        // stalls, and both together.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            for (int i = 0; i < RANDOM_PER_RUN; i++)
                send_word(random_word());
        end
        s_tvalid <= 1'b0;

        // Wait for every predicted word, then a while longer so that a stray
        // extra result word would still be caught.
        while (board.pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatch_count == 0) begin
            $display("** decimal_normalize_round_core: PASSED **");
        end else begin
            $display("** decimal_normalize_round_core: FAILED **");
        end
        $finish;
    end

endmodule
